// ----- src/rqd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue dispatcher package
// Shared types, codes and the rule key function for the ready queue dispatcher.
// ----------------------------------------------------------------------------
package rqd_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int KEY_W               = 32;

    typedef enum logic
    {
        CMD_INSERT   = 1'b0,
        CMD_DISPATCH = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Rule codes held in rule_select. The unused codes behave as shortest time.
    localparam logic [2:0] RULE_SPT     = 3'd0;
    localparam logic [2:0] RULE_LPT     = 3'd1;
    localparam logic [2:0] RULE_MWKR    = 3'd2;
    localparam logic [2:0] RULE_MOPNR   = 3'd3;
    localparam logic [2:0] RULE_RELEASE = 3'd4;

    typedef struct packed
    {
        logic [7:0]  job;
        logic [15:0] proc_ticks;
        logic [19:0] work_left;
        logic [7:0]  ops_left;
        logic [31:0] rel_ticks;
    } entry_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SCAN_END,
        ST_SHIFT,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic ins_write;
        logic rep_full;
        logic rep_empty;
        logic scan_start;
        logic scan_read;
        logic shift_init;
        logic shift_read;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic is_dispatch;
        logic empty;
        logic full;
        logic scan_last;
        logic shift_more;
    } stat_t;

    // Every rule is mapped to a key where the strictly smaller key wins.
    // A "largest wins" rule uses the inverted field.
    function automatic logic [KEY_W-1:0] rule_key(input logic [2:0] rule, input entry_t e);
        logic [KEY_W-1:0] key;
        begin
            unique case (rule)
                RULE_LPT:     key = KEY_W'(~e.proc_ticks);
                RULE_MWKR:    key = KEY_W'(~e.work_left);
                RULE_MOPNR:   key = KEY_W'(~e.ops_left);
                RULE_RELEASE: key = e.rel_ticks;
                default:      key = KEY_W'(e.proc_ticks);
            endcase
            return key;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/ready_queue_rule_dispatcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue rule dispatcher
// Ordered ready queue of one machine with rule based dispatch.
// ----------------------------------------------------------------------------
// The block handles one command at a time. An insert appends an entry at the
// tail of the queue and returns its result. A dispatch with n entries queued
// reads every entry once through the single read port of the queue memory,
// then moves each entry behind the winner one place towards the head, one
// entry a cycle, and then returns its result. A dispatch from an empty queue
// or an insert into a full one returns its result with the queue untouched.
// The next input transaction is taken once the result transaction has
// completed. The rule register may be written at any time the block is idle;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ready_queue_rule_dispatcher
#(
    parameter int QUEUE_DEPTH = rqd_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration channel: rule_select
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,
    // Command channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [7:0]  in_job,
    input  wire logic [15:0] in_proc_time,
    input  wire logic [19:0] in_work_left,
    input  wire logic [7:0]  in_ops_left,
    input  wire logic [31:0] in_release,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             picked_valid,
    output logic [7:0]       picked_job,
    output logic [15:0]      picked_proc_time,
    output logic [4:0]       queue_level
);
    import rqd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The rule register is a plain register, so a write is always taken.
    assign cfg_ready = 1'b1;

    // The controller steps each command through execute, scan and compaction.
    rqd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the queue memory, the rule compare and the results.
    rqd_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .command          (command),
        .in_job           (in_job),
        .in_proc_time     (in_proc_time),
        .in_work_left     (in_work_left),
        .in_ops_left      (in_ops_left),
        .in_release       (in_release),
        .status           (status),
        .picked_valid     (picked_valid),
        .picked_job       (picked_job),
        .picked_proc_time (picked_proc_time),
        .queue_level      (queue_level)
    );

endmodule
`default_nettype wire

// ----- src/rqd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue dispatcher controller
// Sequences insert, scan and compaction steps and runs both handshakes.
// ----------------------------------------------------------------------------
module rqd_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire rqd_pkg::stat_t stat,
    output rqd_pkg::cmd_t      cmd
);
    import rqd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.is_dispatch)
                begin
                    if (stat.full)
                    begin
                        cmd.rep_full = 1'b1;
                    end
                    else
                    begin
                        cmd.ins_write = 1'b1;
                    end
                    state_next = ST_RESP;
                end
                else if (stat.empty)
                begin
                    cmd.rep_empty = 1'b1;
                    state_next    = ST_RESP;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                cmd.shift_init = 1'b1;
                state_next     = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (stat.shift_more)
                begin
                    cmd.shift_read = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/rqd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue dispatcher datapath
// Queue memory, fill count, rule comparison and result registers.
// ----------------------------------------------------------------------------
module rqd_datapath
#(
    parameter int QUEUE_DEPTH = rqd_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rqd_pkg::cmd_t   cmd,
    output rqd_pkg::stat_t       stat,
    input  wire logic            cfg_write,
    input  wire logic [2:0]      cfg_data,
    input  wire logic            command,
    input  wire logic [7:0]      in_job,
    input  wire logic [15:0]     in_proc_time,
    input  wire logic [19:0]     in_work_left,
    input  wire logic [7:0]      in_ops_left,
    input  wire logic [31:0]     in_release,
    output logic [1:0]           status,
    output logic                 picked_valid,
    output logic [7:0]           picked_job,
    output logic [15:0]          picked_proc_time,
    output logic [4:0]           queue_level
);
    import rqd_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W = (CNT_W > 5) ? CNT_W : 5;

    entry_t mem [QUEUE_DEPTH];

    logic [2:0]       rule_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    entry_t           rd_data_reg;
    logic             cmp_pend_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             sh_pend_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [7:0]       best_job_reg;
    logic [15:0]      best_proc_reg;
    logic             item_cmd_reg;
    entry_t           item_reg;
    status_t          status_reg;
    logic             picked_valid_reg;
    logic [7:0]       picked_job_reg;
    logic [15:0]      picked_proc_reg;

    logic [KEY_W-1:0] cand_key;
    logic             take;
    logic [IDX_W-1:0] best_idx_next;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic             mem_re;
    logic [CNT_W-1:0] rd_idx_plus;
    logic [LEVEL_W-1:0] level_wide;

    assign cand_key      = rule_key(rule_reg, rd_data_reg);
    assign take          = cmp_pend_reg && ((cmp_idx_reg == '0) || (cand_key < best_key_reg));
    assign best_idx_next = take ? cmp_idx_reg : best_idx_reg;
    assign rd_idx_plus   = rd_idx_reg + CNT_W'(1);

    assign stat.is_dispatch = (item_cmd_reg == CMD_DISPATCH);
    assign stat.empty       = (fill_reg == '0);
    assign stat.full        = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.scan_last   = (rd_idx_plus == fill_reg);
    assign stat.shift_more  = (rd_idx_reg < fill_reg);

    assign mem_we = cmd.ins_write || sh_pend_reg;
    assign mem_wa = cmd.ins_write ? fill_reg[IDX_W-1:0] : wr_idx_reg;
    assign mem_wd = cmd.ins_write ? item_reg : rd_data_reg;
    assign mem_re = cmd.scan_read || cmd.shift_read;

    // Queue storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg     <= RULE_SPT;
            fill_reg     <= '0;
            cmp_pend_reg <= 1'b0;
            sh_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                rule_reg <= cfg_data;
            end
            cmp_pend_reg <= cmd.scan_read;
            sh_pend_reg  <= cmd.shift_read;
            if (cmd.ins_write)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_cmd_reg        <= command;
            item_reg.job        <= in_job;
            item_reg.proc_ticks <= in_proc_time;
            item_reg.work_left  <= in_work_left;
            item_reg.ops_left   <= in_ops_left;
            item_reg.rel_ticks  <= in_release;
        end

        if (cmd.scan_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.shift_init)
        begin
            rd_idx_reg <= CNT_W'(best_idx_next) + CNT_W'(1);
        end
        else if (mem_re)
        begin
            rd_idx_reg <= rd_idx_plus;
        end

        cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];

        if (cmd.shift_init)
        begin
            wr_idx_reg <= best_idx_next;
        end
        else if (sh_pend_reg)
        begin
            wr_idx_reg <= wr_idx_reg + IDX_W'(1);
        end

        if (take)
        begin
            best_key_reg  <= cand_key;
            best_idx_reg  <= cmp_idx_reg;
            best_job_reg  <= rd_data_reg.job;
            best_proc_reg <= rd_data_reg.proc_ticks;
        end

        if (cmd.ins_write || cmd.rep_full || cmd.rep_empty)
        begin
            picked_valid_reg <= 1'b0;
            picked_job_reg   <= '0;
            picked_proc_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            picked_valid_reg <= 1'b1;
            picked_job_reg   <= best_job_reg;
            picked_proc_reg  <= best_proc_reg;
        end

        priority if (cmd.rep_full)
        begin
            status_reg <= STATUS_FULL;
        end
        else if (cmd.rep_empty)
        begin
            status_reg <= STATUS_EMPTY;
        end
        else if (cmd.ins_write || cmd.finish)
        begin
            status_reg <= STATUS_OK;
        end
        else
        begin
            status_reg <= status_reg;
        end
    end

    assign level_wide       = LEVEL_W'(fill_reg);
    assign queue_level      = level_wide[4:0];
    assign status           = status_reg;
    assign picked_valid     = picked_valid_reg;
    assign picked_job       = picked_job_reg;
    assign picked_proc_time = picked_proc_reg;

endmodule
`default_nettype wire
